@@ src/vspd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the vital-sign packet deframer.
// No dependencies; imported by the deframer top level and its checker.
package vspd_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 64;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_FIELDS = 7;

    // Shortest payload, id byte included, that carries a full vital record.
    localparam logic [BYTE_W-1:0] VITAL_MIN_LEN = 8'd8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VITAL_ID    = 2'd2;

    // Register reset values.
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h66;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hCC;
    localparam logic [BYTE_W-1:0] VITAL_ID_RST    = 8'h01;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_VITAL     = 2'd0,
        ST_CSUM_FAIL = 2'd1,
        ST_TOO_SHORT = 2'd2,
        ST_OTHER_ID  = 2'd3
    } status_t;

    // Framing state, one-hot.
    typedef enum logic [4:0] {
        PH_SYNC1   = 5'b00001,
        PH_SYNC2   = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CHECK   = 5'b10000
    } phase_t;

endpackage

@@ src/vital_sign_packet_deframer_unit.sv @@
`timescale 1ns / 1ps
// Vital-sign packet deframer: byte-serial framing machine with registered
// input and output words. Depends on vspd_pkg.
//
// Usage: received serial bytes enter one word at a time on the slave stream
// (s_tvalid, s_tready, s_tdata). The block hunts for two sync bytes, reads a
// length byte, that many payload bytes (packet id first) and a checksum byte.
// For each packet one result word leaves on the master stream: the status in
// m_tuser and the id and vital-sign fields in m_tdata.
// A checksum byte passes through the input register and, once framed, into
// the result register, which raises m_tvalid when it is loaded.
// Throughput: one byte per cycle. Bytes other than a checksum byte are always
// taken; a checksum byte waits in the input register only while an earlier
// result is still held on the master side, so s_tready drops just then.
// Reset (rst_n low, asynchronous) returns to hunting the first sync byte,
// empties both registers and loads the sync and id registers with 0x66, 0xCC
// and 0x01. When the receiver stalls, the pending result holds steady and the
// framing of further bytes goes on until the next checksum byte.
// Configuration must be written via cfg_we/cfg_index/cfg_data only when idle;
// not enforced by the block; 0 is the first sync, 1 second, 2 vital packet id.
module vital_sign_packet_deframer_unit
    import vspd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data,
    // Received bytes.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // rx_byte[7:0]
    // Packet results.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // packet_id[7:0], heart_rate[15:8], breath_rate[23:16],
    // temperature_tenths[39:24], pressure_high[47:40], pressure_low[55:48],
    // oxygen[63:56]
    output logic [TDATA_W-1:0]    m_tdata,
    output logic [STATUS_W-1:0]   m_tuser    // status[1:0]
);

    // Configuration registers.
    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [BYTE_W-1:0] vital_id_reg;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Framing state.
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] length_reg;
    logic [BYTE_W-1:0] index_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] id_reg;
    logic [BYTE_W-1:0] fields_reg [NUM_FIELDS];

    // Result register.
    logic                out_valid_reg;
    logic [TDATA_W-1:0]  out_data_reg, out_data_next;
    logic [STATUS_W-1:0] out_status_reg;
    status_t             status_next;

    logic stall;
    logic step;
    logic finish;
    logic [BYTE_W-1:0] sum_add;
    logic [BYTE_W-1:0] index_inc;

    // A checksum byte can only retire when the result register is free or
    // is being emptied in this cycle.
    assign stall    = in_valid_reg && (phase_reg == PH_CHECK) && out_valid_reg && !m_tready;
    assign s_tready = !stall;
    assign step     = in_valid_reg && !stall;
    assign finish   = step && (phase_reg == PH_CHECK);

    assign sum_add   = sum_reg + in_byte_reg;
    assign index_inc = index_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            vital_id_reg    <= VITAL_ID_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                CFG_VITAL_ID:    vital_id_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // The input register refills whenever its word retires or it is empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SYNC1:   phase_next = (in_byte_reg == sync_first_reg) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2:   phase_next = (in_byte_reg == sync_second_reg) ? PH_LEN : PH_SYNC1;
            PH_LEN:     phase_next = (in_byte_reg == '0) ? PH_CHECK : PH_PAYLOAD;
            PH_PAYLOAD: phase_next = (index_inc == length_reg) ? PH_CHECK : PH_PAYLOAD;
            PH_CHECK:   phase_next = PH_SYNC1;
            default:    phase_next = PH_SYNC1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            length_reg <= '0;
            index_reg  <= '0;
            sum_reg    <= '0;
            id_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            if (phase_reg == PH_LEN)
            begin
                length_reg <= in_byte_reg;
                sum_reg    <= in_byte_reg;
                index_reg  <= '0;
                id_reg     <= '0;
            end
            else if (phase_reg == PH_PAYLOAD)
            begin
                sum_reg   <= sum_add;
                index_reg <= index_inc;
                if (index_reg == '0)
                begin
                    id_reg <= in_byte_reg;
                end
            end
        end
    end

    // Payload bytes one to seven. They reach the result only for a vital
    // record, which is at least eight bytes long, so every one of them has
    // been written within the same packet and needs no clearing.
    always_ff @(posedge clk)
    begin
        if (step && (phase_reg == PH_PAYLOAD))
        begin
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                if (index_reg == BYTE_W'(k + 1))
                begin
                    fields_reg[k] <= in_byte_reg;
                end
            end
        end
    end

    // Result decode for the checksum byte.
    always_comb
    begin
        out_data_next = '0;
        out_data_next[7:0] = id_reg;
        if (in_byte_reg != sum_reg)
        begin
            status_next = ST_CSUM_FAIL;
        end
        else if ((length_reg != '0) && (id_reg == vital_id_reg))
        begin
            if (length_reg < VITAL_MIN_LEN)
            begin
                status_next = ST_TOO_SHORT;
            end
            else
            begin
                status_next = ST_VITAL;
                out_data_next[15:8]  = fields_reg[0];
                out_data_next[23:16] = fields_reg[1];
                out_data_next[31:24] = fields_reg[3];
                out_data_next[39:32] = fields_reg[2];
                out_data_next[47:40] = fields_reg[4];
                out_data_next[55:48] = fields_reg[5];
                out_data_next[63:56] = fields_reg[6];
            end
        end
        else
        begin
            status_next = ST_OTHER_ID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

@@ src/vspd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the vital-sign packet deframer, with its bind.
// Depends on vspd_pkg and vital_sign_packet_deframer_unit.
module vspd_checker
    import vspd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [TDATA_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // A pending result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Anything but a vital record carries only the packet id.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_VITAL) |-> (m_tdata[TDATA_W-1:8] == '0))
        else $error("non-vital result carries data fields");

    // A fresh result word is preceded by an accepted byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result word without a checksum byte");

endmodule

bind vital_sign_packet_deframer_unit vspd_checker u_vspd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
